@@ design/tcs_pkg.sv @@
// ============================================================================
// tcs_pkg : shared constants for the tetrahedron circumsphere pipeline
// Multiplier slice width and the latency rule of the sliced multiplier.
// ============================================================================
package tcs_pkg;

    // width of one operand slice fed to a single hardware multiplier
    localparam int MUL_CHUNK = 32;

    // stages of tcs_mul: magnitude stage, one stage per slice pair, sign stage
    function automatic int mul_lat(input int aw, input int bw);
        return ((aw + MUL_CHUNK - 1) / MUL_CHUNK) * ((bw + MUL_CHUNK - 1) / MUL_CHUNK) + 2;
    endfunction

endpackage

@@ design/tetrahedron_circumsphere_top.sv @@
// Datapath: edge and cofactor multiplies, Cramer products, rounding, W+2 divider, W-1 root;
//   the valid bit rides along a delay line T_END deep.
// Throughput: one word per cycle while the output buffer is not full; all stages step together on a shared enable.
// Stalls: a two-entry output buffer holds results; the pipeline freezes when it is full.
// Reset: synchronous, active low; clears valid bits, side-band delay lines and the output
//   buffer flags; arithmetic registers are not reset.
// ============================================================================
// tetrahedron_circumsphere_top : circumscribed sphere of a tetrahedron
// Exact integer Cramer solve, rounded divide, saturation and integer root.
// ============================================================================
module tetrahedron_circumsphere_top #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_WIDTH-1:0] i_p0_x,
    input  logic signed [COORD_WIDTH-1:0] i_p0_y,
    input  logic signed [COORD_WIDTH-1:0] i_p0_z,
    input  logic signed [COORD_WIDTH-1:0] i_p1_x,
    input  logic signed [COORD_WIDTH-1:0] i_p1_y,
    input  logic signed [COORD_WIDTH-1:0] i_p1_z,
    input  logic signed [COORD_WIDTH-1:0] i_p2_x,
    input  logic signed [COORD_WIDTH-1:0] i_p2_y,
    input  logic signed [COORD_WIDTH-1:0] i_p2_z,
    input  logic signed [COORD_WIDTH-1:0] i_p3_x,
    input  logic signed [COORD_WIDTH-1:0] i_p3_y,
    input  logic signed [COORD_WIDTH-1:0] i_p3_z,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_WIDTH-1:0] o_center_x,
    output logic signed [COORD_WIDTH-1:0] o_center_y,
    output logic signed [COORD_WIDTH-1:0] o_center_z,
    output logic        [COORD_WIDTH-2:0] o_radius,
    output logic                          o_degenerate,
    output logic                          o_saturated
);
    import tcs_pkg::*;

    // ---- widths ------------------------------------------------------------
    localparam int W     = COORD_WIDTH;
    localparam int DW1   = W + 1;           // edge vector d = p_i - p0
    localparam int BW2   = 2 * W + 3;       // |d|^2 and 2x2 cofactors
    localparam int NW    = 2 * BW2;         // Cramer numerators and det
    localparam int DENW  = 3 * W + 4;       // 2*|det|
    localparam int QW    = W + 1;           // quotient bits kept before overflow
    localparam int MW    = 3 * W + 3;       // center + flags side band
    localparam int RESW  = 4 * W + 1;       // packed result word
    // ---- stage timing ------------------------------------------------------
    localparam int LM1   = mul_lat(DW1, DW1);
    localparam int LM2   = mul_lat(BW2, BW2);
    localparam int LM3   = mul_lat(W, W);
    localparam int T_G   = 6 + LM1 + LM2 + QW;      // divider outputs
    localparam int T_END = T_G + LM3 + W + 1;       // root outputs

    localparam logic signed [W+2:0] C_MAX = $signed({4'b0000, {(W-1){1'b1}}});
    localparam logic signed [W+2:0] C_MIN = $signed({4'b1111, {(W-1){1'b0}}});
    localparam logic signed [W-1:0] O_MAX = $signed({1'b0, {(W-1){1'b1}}});
    localparam logic signed [W-1:0] O_MIN = $signed({1'b1, {(W-1){1'b0}}});
    localparam logic [W-2:0]        R_MAX = {(W-1){1'b1}};

    logic en;               // whole pipeline steps together
    logic r_skid_v;
    logic r_out_v;
    logic [RESW-1:0] r_skid;
    logic [RESW-1:0] r_out;

    assign en         = !r_skid_v;
    assign o_in_ready = en;

    // ---- stage A: edge vectors ------------------------------------------------
    logic signed [W-1:0]   pin  [0:3][0:2];
    logic signed [DW1-1:0] r_d  [0:2][0:2];
    logic signed [W-1:0]   r_p0 [0:2];

    assign pin[0][0] = i_p0_x;  assign pin[0][1] = i_p0_y;  assign pin[0][2] = i_p0_z;
    assign pin[1][0] = i_p1_x;  assign pin[1][1] = i_p1_y;  assign pin[1][2] = i_p1_z;
    assign pin[2][0] = i_p2_x;  assign pin[2][1] = i_p2_y;  assign pin[2][2] = i_p2_z;
    assign pin[3][0] = i_p3_x;  assign pin[3][1] = i_p3_y;  assign pin[3][2] = i_p3_z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_d[i][k] <= DW1'(pin[i+1][k]) - DW1'(pin[0][k]);
                end
            end
            for (int k = 0; k < 3; k++) r_p0[k] <= pin[0][k];
        end
    end

    // ---- stage B: squares and cofactor products ---------------------------------
    // Cyclic indexing gives the signed 3x3 cofactor directly.
    logic signed [2*DW1-1:0] w_sq [0:2][0:2];
    logic signed [2*DW1-1:0] w_pa [0:2][0:2];
    logic signed [2*DW1-1:0] w_pb [0:2][0:2];
    logic [DW1-1:0]          w_d0 [0:2];

    for (genvar gi = 0; gi < 3; gi++) begin : g_row
        for (genvar gk = 0; gk < 3; gk++) begin : g_col
            tcs_mul #(.AW(DW1), .BW(DW1)) u_sq (
                .i_clk(i_clk), .i_en(en),
                .i_a(r_d[gi][gk]), .i_b(r_d[gi][gk]), .o_p(w_sq[gi][gk]));
            tcs_mul #(.AW(DW1), .BW(DW1)) u_pa (
                .i_clk(i_clk), .i_en(en),
                .i_a(r_d[(gi+1)%3][(gk+1)%3]), .i_b(r_d[(gi+2)%3][(gk+2)%3]),
                .o_p(w_pa[gi][gk]));
            tcs_mul #(.AW(DW1), .BW(DW1)) u_pb (
                .i_clk(i_clk), .i_en(en),
                .i_a(r_d[(gi+1)%3][(gk+2)%3]), .i_b(r_d[(gi+2)%3][(gk+1)%3]),
                .o_p(w_pb[gi][gk]));
        end
        // first column rides along for the det expansion
        tcs_delay #(.WD(DW1), .DEPTH(LM1 + 1)) u_d0_dly (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_d(r_d[gi][0]), .o_q(w_d0[gi]));
    end

    // ---- stage C: |d_i|^2 and cofactors -------------------------------------------
    logic signed [BW2-1:0] r_b [0:2];
    logic signed [BW2-1:0] r_c [0:2][0:2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_b[i] <= BW2'(w_sq[i][0]) + BW2'(w_sq[i][1]) + BW2'(w_sq[i][2]);
                for (int k = 0; k < 3; k++) begin
                    r_c[i][k] <= BW2'(w_pa[i][k]) - BW2'(w_pb[i][k]);
                end
            end
        end
    end

    // ---- stage D: det and Cramer numerator terms ----------------------------------
    logic signed [BW2-1:0] w_d0x [0:2];
    logic signed [NW-1:0]  w_nk  [0:2][0:2];
    logic signed [NW-1:0]  w_dt  [0:2];

    for (genvar gi = 0; gi < 3; gi++) begin : g_dterm
        assign w_d0x[gi] = BW2'($signed(w_d0[gi]));
        tcs_mul #(.AW(BW2), .BW(BW2)) u_dt (
            .i_clk(i_clk), .i_en(en),
            .i_a(w_d0x[gi]), .i_b(r_c[gi][0]), .o_p(w_dt[gi]));
        for (genvar gk = 0; gk < 3; gk++) begin : g_nterm
            tcs_mul #(.AW(BW2), .BW(BW2)) u_nk (
                .i_clk(i_clk), .i_en(en),
                .i_a(r_b[gi]), .i_b(r_c[gi][gk]), .o_p(w_nk[gk][gi]));
        end
    end

    // ---- stage E: sums ------------------------------------------------------------
    logic signed [NW-1:0] r_det;
    logic signed [NW-1:0] r_n [0:2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_det <= w_dt[0] + w_dt[1] + w_dt[2];
            for (int k = 0; k < 3; k++) r_n[k] <= w_nk[k][0] + w_nk[k][1] + w_nk[k][2];
        end
    end

    // ---- stage F: magnitudes, then round-to-nearest numerator -----------------------
    // q = (|N| + |det|) / (2|det|) gives ties away from zero.
    logic [NW-1:0]   r_an [0:2];
    logic [DENW-1:0] r_ad;
    logic [2:0]      r_neg1;
    logic            r_dg1;
    logic [NW-1:0]   r_num [0:2];
    logic [DENW-1:0] r_den;
    logic [3:0]      r_ngd2;        // {dg, neg[2:0]}

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_an[k]   <= r_n[k][NW-1] ? NW'(-r_n[k]) : NW'(r_n[k]);
                r_neg1[k] <= r_n[k][NW-1] ^ r_det[NW-1];
            end
            r_ad  <= r_det[NW-1] ? DENW'(-r_det) : DENW'(r_det);
            r_dg1 <= (r_det == '0);

            for (int k = 0; k < 3; k++) r_num[k] <= r_an[k] + NW'(r_ad);
            r_den  <= {r_ad[DENW-2:0], 1'b0};
            r_ngd2 <= {r_dg1, r_neg1};
        end
    end

    // ---- stage G: dividers -----------------------------------------------------------
    logic [QW-1:0]  w_q   [0:2];
    logic [2:0]     w_ovf;
    logic [3:0]     w_ngd;
    logic [3*W-1:0] w_p0d;

    for (genvar gk = 0; gk < 3; gk++) begin : g_div
        tcs_div #(.NW(NW), .DW(DENW), .QW(QW)) u_div (
            .i_clk(i_clk), .i_en(en),
            .i_num(r_num[gk]), .i_den(r_den),
            .o_q(w_q[gk]), .o_ovf(w_ovf[gk]));
    end

    tcs_delay #(.WD(4), .DEPTH(QW + 1)) u_ngd_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(r_ngd2), .o_q(w_ngd));

    tcs_delay #(.WD(3*W), .DEPTH(T_G - 1)) u_p0_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_d({r_p0[0], r_p0[1], r_p0[2]}), .o_q(w_p0d));

    // ---- stage H: signed offset, center with clipping ----------------------------------
    logic signed [W-1:0] w_p0k [0:2];
    logic signed [W+2:0] w_u   [0:2];
    logic signed [W+2:0] w_c   [0:2];
    logic signed [W-1:0] w_cs  [0:2];
    logic [2:0]          w_csat;
    logic [2:0]          w_big;

    for (genvar gk = 0; gk < 3; gk++) begin : g_p0
        assign w_p0k[gk] = w_p0d[(2-gk)*W +: W];
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_u[k] = w_ngd[k] ? -$signed((W+3)'(w_q[k])) : $signed((W+3)'(w_q[k]));
            w_c[k] = w_u[k] + (W+3)'(w_p0k[k]);
            // overflowed quotient dwarfs p0: direction follows the sign
            if (w_ovf[k]) begin
                w_cs[k]   = w_ngd[k] ? O_MIN : O_MAX;
                w_csat[k] = 1'b1;
            end else if (w_c[k] > C_MAX) begin
                w_cs[k]   = O_MAX;
                w_csat[k] = 1'b1;
            end else if (w_c[k] < C_MIN) begin
                w_cs[k]   = O_MIN;
                w_csat[k] = 1'b1;
            end else begin
                w_cs[k]   = W'(w_c[k]);
                w_csat[k] = 1'b0;
            end
            w_big[k] = w_ovf[k] || (w_q[k][W:W-1] != 2'b00);
        end
    end

    logic signed [W-1:0] r_cen [0:2];
    logic [W-2:0]        r_qm  [0:2];
    logic                r_csat;
    logic                r_rbig;
    logic                r_dgh;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_cen[k] <= w_cs[k];
                r_qm[k]  <= w_q[k][W-2:0];
            end
            r_csat <= |w_csat;
            r_rbig <= |w_big;
            r_dgh  <= w_ngd[3];
        end
    end

    // ---- stage I: squared offsets --------------------------------------------------------
    logic signed [W-1:0]   w_qs  [0:2];
    logic signed [2*W-1:0] w_usq [0:2];
    logic [MW-1:0]         w_m1;

    for (genvar gk = 0; gk < 3; gk++) begin : g_usq
        assign w_qs[gk] = {1'b0, r_qm[gk]};
        tcs_mul #(.AW(W), .BW(W)) u_usq (
            .i_clk(i_clk), .i_en(en),
            .i_a(w_qs[gk]), .i_b(w_qs[gk]), .o_p(w_usq[gk]));
    end

    tcs_delay #(.WD(MW), .DEPTH(LM3)) u_m1_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_d({r_cen[0], r_cen[1], r_cen[2], r_csat, r_rbig, r_dgh}), .o_q(w_m1));

    // ---- stage J: radius squared and radius overflow --------------------------------------
    logic [2*W-1:0] w_s;
    logic           w_over;
    logic [2*W-3:0] r_s;
    logic [MW-1:0]  r_m2;           // {center, sat, over, dg}

    assign w_s    = w_usq[0] + w_usq[1] + w_usq[2];
    assign w_over = w_m1[1] || (w_s[2*W-1:2*W-2] != 2'b00);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s  <= w_s[2*W-3:0];
            r_m2 <= {w_m1[MW-1:3], w_m1[2] | w_over, w_over, w_m1[0]};
        end
    end

    // ---- stage K: integer root ---------------------------------------------------------------
    logic [W-2:0]  w_root;
    logic [MW-1:0] w_m3;
    logic          w_v;

    tcs_sqrt #(.RW(W-1)) u_sqrt (
        .i_clk(i_clk), .i_en(en), .i_s(r_s), .o_root(w_root));

    tcs_delay #(.WD(MW), .DEPTH(W - 1)) u_m3_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(r_m2), .o_q(w_m3));

    // valid bit for each word in flight
    tcs_delay #(.WD(1), .DEPTH(T_END)) u_v_dly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(i_in_valid), .o_q(w_v));

    // ---- result assembly: coplanar points give zeros -----------------------------------------
    logic [RESW-1:0] w_res;

    always_comb begin
        if (w_m3[0]) begin
            w_res = {{(3*W){1'b0}}, {(W-1){1'b0}}, 1'b1, 1'b0};
        end else begin
            w_res = {w_m3[MW-1:3], w_m3[1] ? R_MAX : w_root, 1'b0, w_m3[2]};
        end
    end

    // ---- output register plus skid entry --------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (r_skid_v) begin
                if (i_out_ready) begin
                    r_out    <= r_skid;
                    r_skid_v <= 1'b0;
                end
            end else if (!r_out_v || i_out_ready) begin
                r_out_v <= w_v;
                r_out   <= w_res;
            end else if (w_v) begin
                r_skid_v <= 1'b1;
                r_skid   <= w_res;
            end
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_center_x   = r_out[RESW-1 -: W];
    assign o_center_y   = r_out[RESW-1-W -: W];
    assign o_center_z   = r_out[RESW-1-2*W -: W];
    assign o_radius     = r_out[W:2];
    assign o_degenerate = r_out[1];
    assign o_saturated  = r_out[0];
endmodule

@@ design/tcs_delay.sv @@
// ============================================================================
// tcs_delay : enabled shift line
// Carries side data alongside the arithmetic stages, DEPTH registers deep.
// ============================================================================
module tcs_delay #(
    parameter int WD    = 8,
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [WD-1:0] i_d,
    output logic [WD-1:0] o_q
);
    logic [WD-1:0] r_stg [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < DEPTH; t++) r_stg[t] <= '0;
        end else if (i_en) begin
            r_stg[0] <= i_d;
            for (int t = 1; t < DEPTH; t++) r_stg[t] <= r_stg[t-1];
        end
    end

    assign o_q = r_stg[DEPTH-1];
endmodule

@@ design/tcs_mul.sv @@
// ============================================================================
// tcs_mul : pipelined signed multiplier
// Magnitudes are split in MUL_CHUNK slices; one slice product accumulated per stage.
// ============================================================================
module tcs_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [AW-1:0]      i_a,
    input  logic signed [BW-1:0]      i_b,
    output logic signed [AW+BW-1:0]   o_p
);
    import tcs_pkg::*;

    localparam int PW  = AW + BW;
    localparam int NA  = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int NB  = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int NP  = NA * NB;
    localparam int AXW = NA * MUL_CHUNK;
    localparam int BXW = NB * MUL_CHUNK;

    logic [AW-1:0]  a_mag;
    logic [BW-1:0]  b_mag;
    logic [AXW-1:0] r_a   [0:NP-1];
    logic [BXW-1:0] r_b   [0:NP-1];
    logic [PW-1:0]  r_acc [0:NP];
    logic           r_neg [0:NP];
    logic [PW-1:0]  r_p;

    assign a_mag = i_a[AW-1] ? (~i_a + 1'b1) : i_a;
    assign b_mag = i_b[BW-1] ? (~i_b + 1'b1) : i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a[0]   <= AXW'(a_mag);
            r_b[0]   <= BXW'(b_mag);
            r_acc[0] <= '0;
            r_neg[0] <= i_a[AW-1] ^ i_b[BW-1];
        end
    end

    for (genvar k = 0; k < NP; k++) begin : g_pp
        localparam int I  = k / NB;
        localparam int J  = k % NB;
        localparam int SH = MUL_CHUNK * (I + J);
        logic [2*MUL_CHUNK-1:0] pp;

        assign pp = r_a[k][I*MUL_CHUNK +: MUL_CHUNK] * r_b[k][J*MUL_CHUNK +: MUL_CHUNK];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k+1] <= r_acc[k] + (PW'(pp) << SH);
                r_neg[k+1] <= r_neg[k];
            end
        end

        if (k < NP - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_a[k+1] <= r_a[k];
                    r_b[k+1] <= r_b[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_p <= r_neg[NP] ? (~r_acc[NP] + 1'b1) : r_acc[NP];
    end

    assign o_p = r_p;
endmodule

@@ design/tcs_div.sv @@
// ============================================================================
// tcs_div : pipelined restoring divider
// Quotient limited to QW bits; larger quotients raise the overflow flag.
// ============================================================================
module tcs_div #(
    parameter int NW = 134,
    parameter int DW = 100,
    parameter int QW = 33
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_q,
    output logic          o_ovf
);
    localparam int HW = NW - QW;

    logic [HW-1:0] hi;
    logic [DW-1:0] r_rem [0:QW];
    logic [DW-1:0] r_den [0:QW];
    logic [QW-1:0] r_low [0:QW];
    logic [QW-1:0] r_q   [0:QW];
    logic          r_ovf [0:QW];

    assign hi = i_num[NW-1:QW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= hi >= HW'(i_den);
            r_rem[0] <= DW'(hi);
            r_den[0] <= i_den;
            r_low[0] <= i_num[QW-1:0];
            r_q[0]   <= '0;
        end
    end

    for (genvar t = 0; t < QW; t++) begin : g_stg
        logic [DW:0] trial;
        logic        ge;

        assign trial = {r_rem[t], r_low[t][QW-1]};
        assign ge    = trial >= (DW+1)'(r_den[t]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[t+1] <= ge ? DW'(trial - (DW+1)'(r_den[t])) : DW'(trial);
                r_den[t+1] <= r_den[t];
                r_low[t+1] <= r_low[t] << 1;
                r_q[t+1]   <= {r_q[t][QW-2:0], ge};
                r_ovf[t+1] <= r_ovf[t];
            end
        end
    end

    assign o_q   = r_q[QW];
    assign o_ovf = r_ovf[QW];
endmodule

@@ design/tcs_sqrt.sv @@
// ============================================================================
// tcs_sqrt : pipelined integer square root
// Digit by digit, one root bit per stage, floor of the root.
// ============================================================================
module tcs_sqrt #(
    parameter int RW = 31
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*RW-1:0] i_s,
    output logic [RW-1:0]   o_root
);
    localparam int SW = 2 * RW;

    logic [SW-1:0] r_s    [0:RW-1];
    logic [RW+1:0] r_rem  [0:RW-1];
    logic [RW-1:0] r_root [0:RW-1];

    for (genvar t = 0; t < RW; t++) begin : g_stg
        logic [SW-1:0] in_s;
        logic [RW+1:0] in_rem;
        logic [RW-1:0] in_root;
        logic [RW+1:0] rem2;
        logic [RW+1:0] trial;
        logic          ge;

        if (t == 0) begin : g_first
            assign in_s    = i_s;
            assign in_rem  = '0;
            assign in_root = '0;
        end else begin : g_next
            assign in_s    = r_s[t-1];
            assign in_rem  = r_rem[t-1];
            assign in_root = r_root[t-1];
        end

        assign rem2  = {in_rem[RW-1:0], in_s[SW-1:SW-2]};
        assign trial = {in_root, 2'b01};
        assign ge    = rem2 >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[t]    <= in_s << 2;
                r_rem[t]  <= ge ? (rem2 - trial) : rem2;
                r_root[t] <= {in_root[RW-2:0], ge};
            end
        end
    end

    assign o_root = r_root[RW-1];
endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_top : tetrahedron circumsphere testbench
// Sends tetrahedra through the valid/ready input, predicts each sphere with
// exact wide integer arithmetic and compares every output word field by field.
// Covers extremes, coplanar sets, saturation, random flow control and a long
// output stall.
// ============================================================================
module tb_top;

    localparam int W         = 32;
    localparam int CYC_LIMIT = 400000;
    localparam int DRAIN     = 300;     // > pipeline latency

    typedef logic signed [255:0] wide_t;
    typedef logic signed [W-1:0] coord_t;

    typedef struct packed {
        logic signed [W-1:0] cx;
        logic signed [W-1:0] cy;
        logic signed [W-1:0] cz;
        logic        [W-2:0] rad;
        logic                degen;
        logic                sat;
    } sphere_t;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_in_valid = 1'b0;
    logic   i_out_ready = 1'b0;
    coord_t pin [12];
    logic   o_in_ready;
    logic   o_out_valid;
    coord_t o_center_x, o_center_y, o_center_z;
    logic [W-2:0] o_radius;
    logic   o_degenerate, o_saturated;

    sphere_t sphere_q[$];               // predicted spheres, oldest first
    int      n_fail = 0;
    int      n_sent = 0;
    int      n_got = 0;
    int      n_degen = 0;
    int      n_sat = 0;
    int      idle_pct = 0;              // sender idle odds, percent
    int      stall_pct = 0;             // receiver stall odds, percent
    int      hold_req = 0;              // request for a long receiver hold-off
    int      hold_left = 0;
    longint  cycles = 0;

    initial begin
        for (int i = 0; i < 12; i++) pin[i] = '0;
    end

    tetrahedron_circumsphere_top #(.COORD_WIDTH(W)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_p0_x      (pin[0]),
        .i_p0_y      (pin[1]),
        .i_p0_z      (pin[2]),
        .i_p1_x      (pin[3]),
        .i_p1_y      (pin[4]),
        .i_p1_z      (pin[5]),
        .i_p2_x      (pin[6]),
        .i_p2_y      (pin[7]),
        .i_p2_z      (pin[8]),
        .i_p3_x      (pin[9]),
        .i_p3_y      (pin[10]),
        .i_p3_z      (pin[11]),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_center_x  (o_center_x),
        .o_center_y  (o_center_y),
        .o_center_z  (o_center_z),
        .o_radius    (o_radius),
        .o_degenerate(o_degenerate),
        .o_saturated (o_saturated)
    );

    // 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sphere predictor: exact integer Cramer solve on offsets from p0
    // ------------------------------------------------------------------
    function automatic wide_t det_3x3(input wide_t m [9]);
        return m[0] * (m[4] * m[8] - m[5] * m[7])
             - m[1] * (m[3] * m[8] - m[5] * m[6])
             + m[2] * (m[3] * m[7] - m[4] * m[6]);
    endfunction

    function automatic sphere_t circumsphere(input coord_t c [12]);
        wide_t       d [9];
        wide_t       dk [9];
        wide_t       rhs [3];
        wide_t       u [3];
        wide_t       det, num, an, ad, q, ctr, s;
        wide_t       cmax, cmin, lim;
        logic [63:0] s64, r, t;
        logic        over;
        sphere_t     res;
        cmax = 256'sd2147483647;
        cmin = -cmax - 1;
        lim  = cmax + 1;
        res  = '0;
        over = 1'b0;
        for (int i = 0; i < 3; i++) begin
            rhs[i] = 0;
            for (int k = 0; k < 3; k++) begin
                d[i*3+k] = wide_t'(c[(i+1)*3+k]) - wide_t'(c[k]);
                rhs[i] += d[i*3+k] * d[i*3+k];
            end
        end
        det = det_3x3(d);
        if (det == 0) begin
            res.degen = 1'b1;
            return res;
        end
        for (int k = 0; k < 3; k++) begin
            dk = d;
            for (int i = 0; i < 3; i++) dk[i*3+k] = rhs[i];
            num = det_3x3(dk);
            // round half away from zero
            an = (num < 0) ? -num : num;
            ad = (det < 0) ? -det : det;
            q = (an + ad) / (ad + ad);
            u[k] = ((num < 0) != (det < 0)) ? -q : q;
            ctr = wide_t'(c[k]) + u[k];
            if (ctr > cmax) begin
                ctr = cmax;
                res.sat = 1'b1;
            end else if (ctr < cmin) begin
                ctr = cmin;
                res.sat = 1'b1;
            end
            if (k == 0) res.cx = ctr[W-1:0];
            if (k == 1) res.cy = ctr[W-1:0];
            if (k == 2) res.cz = ctr[W-1:0];
            if (((u[k] < 0) ? -u[k] : u[k]) >= lim) over = 1'b1;
        end
        s = 0;
        if (!over) begin
            s = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
            if (s >= lim * lim) over = 1'b1;
        end
        if (over) begin
            res.sat = 1'b1;
            res.rad = '1;
        end else begin
            s64 = s[63:0];
            r = 0;
            for (int b = 30; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= s64) r = t;
            end
            res.rad = r[W-2:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls plus an optional long hold-off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left <= hold_req;
            hold_req = 0;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Result checker: one accepted word against the oldest prediction
    always @(posedge i_clk) begin
        sphere_t e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_got++;
            if (sphere_q.size() == 0) begin
                $error("output word with no prediction pending");
                n_fail++;
            end else begin
                e = sphere_q.pop_front();
                if (o_center_x !== e.cx) begin
                    $error("center_x exp %0d got %0d", e.cx, o_center_x);
                    n_fail++;
                end
                if (o_center_y !== e.cy) begin
                    $error("center_y exp %0d got %0d", e.cy, o_center_y);
                    n_fail++;
                end
                if (o_center_z !== e.cz) begin
                    $error("center_z exp %0d got %0d", e.cz, o_center_z);
                    n_fail++;
                end
                if (o_radius !== e.rad) begin
                    $error("radius exp %0d got %0d", e.rad, o_radius);
                    n_fail++;
                end
                if (o_degenerate !== e.degen) begin
                    $error("degenerate exp %0b got %0b", e.degen, o_degenerate);
                    n_fail++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated exp %0b got %0b", e.sat, o_saturated);
                    n_fail++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: entered right after a rising edge, leaves at the accept edge
    // ------------------------------------------------------------------
    task automatic send_tet(input coord_t c [12]);
        sphere_t e;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        for (int i = 0; i < 12; i++) pin[i] <= c[i];
        do @(posedge i_clk); while (!o_in_ready);
        e = circumsphere(c);
        sphere_q = {sphere_q, e};
        n_sent++;
        if (e.degen) n_degen++;
        if (e.sat) n_sat++;
    endtask

    task automatic go_quiet();
        i_in_valid <= 1'b0;
        wait (sphere_q.size() == 0);
        @(posedge i_clk);
    endtask

    function automatic coord_t pick_extreme();
        case ($urandom_range(4))
            0: return coord_t'(32'h8000_0000);
            1: return coord_t'(32'h7fff_ffff);
            2: return '0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    // random tetrahedron; mostly local clusters, some coplanar and wild ones
    task automatic make_tet(output coord_t c [12]);
        int     mode, span, rv;
        coord_t base;
        mode = $urandom_range(9);
        span = $urandom_range(24, 1);
        rv   = $urandom_range(3, 1);
        for (int k = 0; k < 3; k++) begin
            base = coord_t'($urandom) >>> $urandom_range(8);
            for (int i = 0; i < 4; i++)
                c[i*3+k] = base + coord_t'($urandom_range((1 << span) - 1))
                         - coord_t'(1 << (span - 1));
        end
        case (mode)
            0, 1: for (int i = 0; i < 12; i++) c[i] = coord_t'($urandom);
            7: for (int k = 0; k < 3; k++)       // coplanar: p3 = p1 + p2 - p0
                c[9+k] = c[3+k] + c[6+k] - c[k];
            8: for (int k = 0; k < 3; k++)       // repeated vertex
                c[3*rv+k] = c[k];
            9: for (int k = 0; k < 3; k++)       // nearly flat, huge centre
                c[9+k] = c[3+k] + c[6+k] - c[k] + coord_t'($urandom_range(2)) - 1;
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        coord_t c [12];
        idle_pct = 0;
        stall_pct = 0;
        // all points at origin
        for (int i = 0; i < 12; i++) c[i] = '0;
        send_tet(c);
        // unit corner tetrahedron, Q16.16 and raw units (half-unit ties)
        for (int s = 0; s < 4; s++) begin
            for (int i = 0; i < 12; i++) c[i] = '0;
            c[3] = (s[0] ? -1 : 1) * (s[1] ? 1 : 65536);
            c[7] = c[3];
            c[11] = c[3];
            send_tet(c);
        end
        // corners of the full coordinate cube: radius clips
        for (int i = 0; i < 12; i++) c[i] = coord_t'(32'h8000_0000);
        c[3] = coord_t'(32'h7fff_ffff);
        c[7] = c[3];
        c[11] = c[3];
        send_tet(c);
        for (int i = 0; i < 12; i++) c[i] = -c[i] - 1;
        send_tet(c);
        // collinear points
        for (int i = 0; i < 4; i++)
            for (int k = 0; k < 3; k++) c[i*3+k] = coord_t'(i * (k + 1) * 1000);
        send_tet(c);
        // sliver: near-coplanar, far centre
        for (int i = 0; i < 12; i++) c[i] = '0;
        c[3] = 32'sh4000_0000;
        c[7] = 32'sh4000_0000;
        c[9] = 32'sh4000_0000;
        c[10] = 32'sh4000_0000;
        c[11] = 1;
        send_tet(c);
        // mixtures of extreme coordinate values
        for (int n = 0; n < 14; n++) begin
            for (int i = 0; i < 12; i++) c[i] = pick_extreme();
            send_tet(c);
        end
        go_quiet();
    endtask

    task automatic test_random(input int n, input int idle, input int stall);
        coord_t c [12];
        idle_pct = idle;
        stall_pct = stall;
        for (int j = 0; j < n; j++) begin
            make_tet(c);
            send_tet(c);
        end
        go_quiet();
    endtask

    // output blocked for a long stretch while input keeps offering words;
    // more words than the pipeline holds, so the input stalls
    task automatic test_backpressure();
        coord_t c [12];
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 400;
        for (int j = 0; j < 120; j++) begin
            make_tet(c);
            send_tet(c);
        end
        go_quiet();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(80, 0, 0);
        test_random(70, 84, 0);
        test_random(70, 0, 84);
        test_random(70, 19, 19);
        test_backpressure();
        test_random(20, 0, 0);
        repeat (DRAIN) @(posedge i_clk);
        if (sphere_q.size() != 0) begin
            $error("%0d predicted spheres never arrived", sphere_q.size());
            n_fail++;
        end
        $display("Sent %0d tetrahedra, checked %0d spheres", n_sent, n_got);
        $display("Coplanar sets %0d, clipped results %0d", n_degen, n_sat);
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/tcs_pkg.sv
design/tcs_delay.sv
design/tcs_mul.sv
design/tcs_div.sv
design/tcs_sqrt.sv
design/tetrahedron_circumsphere_top.sv
test/tb_top.sv
